FILE: rtl/core/fsng_pkg.sv
// Package for the FAT short name generator.
// Holds beat types, character constants, the phase enum and the byte helpers.
// No dependencies.
package fsng_pkg;

   localparam logic [15:0] UNIT_DOT       = 16'h002E;
   localparam logic [15:0] UNIT_SPACE     = 16'h0020;
   localparam logic [15:0] UNIT_ASCII_MAX = 16'h007F;

   localparam logic [7:0] BYTE_SPACE      = 8'h20;
   localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
   localparam logic [7:0] BYTE_TILDE      = 8'h7E;
   localparam logic [7:0] BYTE_ONE        = 8'h31;
   localparam logic [7:0] BYTE_LOWER_A    = 8'h61;
   localparam logic [7:0] BYTE_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_OFFSET     = 8'h20;

   localparam int BASE_MAX   = 6;
   localparam int EXT_MAX    = 3;
   localparam int BASE_BYTES = 8;

   typedef enum logic [1:0] {
      PHASE_LEAD = 2'd0,
      PHASE_BASE = 2'd1,
      PHASE_EXT  = 2'd2
   } fsng_phase_type;

   typedef struct packed {
      logic [15:0] name_unit;
      logic        last_unit;
   } fsng_req_type;

   typedef struct packed {
      logic [63:0] base_bytes;
      logic [23:0] ext_bytes;
      logic [7:0]  name_sum;
   } fsng_rsp_type;

   function automatic logic [7:0] map_unit(logic [15:0] unit);
      logic [7:0] c;
      c = {1'b0, unit[6:0]};
      if (unit > UNIT_ASCII_MAX) begin
         c = BYTE_UNDERSCORE;
      end else if (c inside {[BYTE_LOWER_A:BYTE_LOWER_Z]}) begin
         c = c - CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [7:0] sum_step(logic [7:0] sum, logic [7:0] b);
      return {sum[0], sum[7:1]} + b;
   endfunction

endpackage

FILE: rtl/core/fat_short_name_generator.sv
// FAT short name generator: top level.
// Builds an 8.3 short name and its long-name checksum from a UTF-16 name stream.
// Depends on fsng_pkg.
//
// One code unit is taken per cycle as a req beat while req_ready is high; a
// beat with last_unit set closes the name and raises rsp_valid after it passes
// the input register, name assembly, then two checksum stages of six and five
// bytes, while the next name may already stream in. Leading dots are dropped,
// the base keeps up to six characters before the first later dot and gets "~1"
// appended, the extension keeps up to three characters after the last dot,
// spaces are dropped, letters are upper-cased and units above 0x7F become
// underscore. Every stage holds its beat under back-pressure, so stalls never
// lose data.
module fat_short_name_generator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fsng_pkg::fsng_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fsng_pkg::fsng_rsp_type rsp_data
);
   import fsng_pkg::*;

   logic           s0_valid_ff;
   fsng_req_type   s0_data_ff;
   logic           s1_valid_ff;
   logic [63:0]    s1_base_ff;
   logic [23:0]    s1_ext_ff;
   logic           s2_valid_ff;
   logic [63:0]    s2_base_ff;
   logic [23:0]    s2_ext_ff;
   logic [7:0]     s2_sum_ff;
   logic           rsp_valid_ff;
   fsng_rsp_type   rsp_data_ff;

   fsng_phase_type phase_ff, phase_in;
   logic [47:0]    base_store_ff, base_store_in, base_upd;
   logic [2:0]     base_count_ff, base_count_in, base_count_upd;
   logic [23:0]    ext_store_ff, ext_store_in, ext_upd;
   logic [1:0]     ext_count_ff, ext_count_in, ext_count_upd;
   logic           ext_seen_ff, ext_seen_in, ext_seen_upd;

   logic           rdy0, rdy1, rdy2, rdy3;
   logic           consume;
   logic           is_dot, is_space;
   fsng_phase_type upd_phase;
   logic [7:0]     unit_byte;
   logic [47:0]    base_align;
   logic [63:0]    base_wide;
   logic [23:0]    ext_align;
   logic [63:0]    base_word;
   logic [23:0]    ext_word;
   logic [7:0]     sum_lo, sum_hi;

   assign rdy3      = ~rsp_valid_ff | rsp_ready;
   assign rdy2      = ~s2_valid_ff | rdy3;
   assign rdy1      = ~s1_valid_ff | rdy2;
   assign rdy0      = ~s0_valid_ff | rdy1;
   assign req_ready = rdy0;
   assign consume   = s0_valid_ff & rdy1;

   assign is_dot    = (s0_data_ff.name_unit == UNIT_DOT);
   assign is_space  = (s0_data_ff.name_unit == UNIT_SPACE);
   assign unit_byte = map_unit(s0_data_ff.name_unit);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (consume) begin
         if (s0_data_ff.last_unit) begin
            phase_in = PHASE_LEAD;
         end else if (is_dot) begin
            if (phase_ff != PHASE_LEAD) begin
               phase_in = PHASE_EXT;
            end
         end else if (phase_ff == PHASE_LEAD) begin
            phase_in = PHASE_BASE;
         end
      end
   end

   // name buffers
   always_comb begin
      upd_phase      = (phase_ff == PHASE_LEAD && !is_dot) ? PHASE_BASE : phase_ff;
      base_upd       = base_store_ff;
      base_count_upd = base_count_ff;
      ext_upd        = ext_store_ff;
      ext_count_upd  = ext_count_ff;
      ext_seen_upd   = ext_seen_ff;
      if (upd_phase != PHASE_LEAD) begin
         if (is_dot) begin
            ext_seen_upd  = 1'b1;
            ext_upd       = '0;
            ext_count_upd = '0;
         end else if (!is_space) begin
            if (upd_phase == PHASE_BASE) begin
               if (base_count_ff < 3'(BASE_MAX)) begin
                  base_upd       = {base_store_ff[39:0], unit_byte};
                  base_count_upd = base_count_ff + 3'd1;
               end
            end else if (ext_seen_ff && ext_count_ff < 2'(EXT_MAX)) begin
               ext_upd       = {ext_store_ff[15:0], unit_byte};
               ext_count_upd = ext_count_ff + 2'd1;
            end
         end
      end
      if (s0_data_ff.last_unit) begin
         base_store_in = '0;
         base_count_in = '0;
         ext_store_in  = '0;
         ext_count_in  = '0;
         ext_seen_in   = 1'b0;
      end else begin
         base_store_in = base_upd;
         base_count_in = base_count_upd;
         ext_store_in  = ext_upd;
         ext_count_in  = ext_count_upd;
         ext_seen_in   = ext_seen_upd;
      end
   end

   // short name assembly
   always_comb begin
      base_align = base_upd << {3'(BASE_MAX) - base_count_upd, 3'b000};
      base_wide  = {base_align, 16'h0000};
      ext_align  = ext_upd << {2'(EXT_MAX) - ext_count_upd, 3'b000};
      for (int i = 0; i < BASE_BYTES; i++) begin
         if (3'(i) < base_count_upd) begin
            base_word[63 - 8*i -: 8] = base_wide[63 - 8*i -: 8];
         end else if (3'(i) == base_count_upd) begin
            base_word[63 - 8*i -: 8] = BYTE_TILDE;
         end else if (3'(i) == base_count_upd + 3'd1) begin
            base_word[63 - 8*i -: 8] = BYTE_ONE;
         end else begin
            base_word[63 - 8*i -: 8] = BYTE_SPACE;
         end
      end
      for (int i = 0; i < EXT_MAX; i++) begin
         if (2'(i) < ext_count_upd) begin
            ext_word[23 - 8*i -: 8] = ext_align[23 - 8*i -: 8];
         end else begin
            ext_word[23 - 8*i -: 8] = BYTE_SPACE;
         end
      end
   end

   // checksum, first six bytes then the last five
   always_comb begin
      sum_lo = 8'h00;
      for (int i = 0; i < 6; i++) begin
         sum_lo = sum_step(sum_lo, s1_base_ff[63 - 8*i -: 8]);
      end
      sum_hi = sum_step(s2_sum_ff, s2_base_ff[15:8]);
      sum_hi = sum_step(sum_hi, s2_base_ff[7:0]);
      for (int i = 0; i < EXT_MAX; i++) begin
         sum_hi = sum_step(sum_hi, s2_ext_ff[23 - 8*i -: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PHASE_LEAD;
         base_store_ff <= '0;
         base_count_ff <= '0;
         ext_store_ff  <= '0;
         ext_count_ff  <= '0;
         ext_seen_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (rdy0) begin
            s0_valid_ff <= req_valid;
         end
         if (rdy1) begin
            s1_valid_ff <= consume & s0_data_ff.last_unit;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (consume) begin
            base_store_ff <= base_store_in;
            base_count_ff <= base_count_in;
            ext_store_ff  <= ext_store_in;
            ext_count_ff  <= ext_count_in;
            ext_seen_ff   <= ext_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && rdy0) begin
         s0_data_ff <= req_data;
      end
      if (consume && s0_data_ff.last_unit) begin
         s1_base_ff <= base_word;
         s1_ext_ff  <= ext_word;
      end
      if (s1_valid_ff && rdy2) begin
         s2_base_ff <= s1_base_ff;
         s2_ext_ff  <= s1_ext_ff;
         s2_sum_ff  <= sum_lo;
      end
      if (s2_valid_ff && rdy3) begin
         rsp_data_ff.base_bytes <= s2_base_ff;
         rsp_data_ff.ext_bytes  <= s2_ext_ff;
         rsp_data_ff.name_sum   <= sum_hi;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/fsng_checker.sv
// Port-level checks for the FAT short name generator.
// Bound to fat_short_name_generator; depends on fsng_pkg.
module fsng_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input fsng_pkg::fsng_rsp_type rsp_data
);
   import fsng_pkg::*;

   logic [7:0] sum_chk;

   always_comb begin
      sum_chk = 8'h00;
      for (int i = 0; i < BASE_BYTES; i++) begin
         sum_chk = sum_step(sum_chk, rsp_data.base_bytes[63 - 8*i -: 8]);
      end
      for (int i = 0; i < EXT_MAX; i++) begin
         sum_chk = sum_step(sum_chk, rsp_data.ext_bytes[23 - 8*i -: 8]);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp beat right after reset");

   a_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.name_sum == sum_chk)
      else $error("checksum does not match short name bytes");

   a_ext_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ext_bytes[15:8] == BYTE_SPACE
      |-> rsp_data.ext_bytes[7:0] == BYTE_SPACE)
      else $error("extension padding not contiguous");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind fat_short_name_generator fsng_checker u_fsng_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: tb/fat_short_name_generator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the FAT short name generator: a directed table, then random names.
// Every short name and checksum is predicted here and compared against each rsp beat.
// Depends on fsng_pkg and fat_short_name_generator.
module fat_short_name_generator_tb;
   import fsng_pkg::*;

   localparam int NAME_TABLE_LEN = 25;
   localparam int RANDOM_UNITS   = 1500;
   localparam int IDLE_PCT       = 11;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 20;
   localparam int QUIET_LIMIT    = 5000;

   typedef struct packed {
      fsng_req_type beat;
      logic         typed;
      logic [63:0]  base;
      logic [23:0]  ext;
   } name_row_type;

   localparam name_row_type NAME_TABLE [0:NAME_TABLE_LEN-1] = '{
      {UNIT_DOT,   1'b1, 1'b1, 64'h7E31_2020_2020_2020, 24'h202020},
      {UNIT_DOT,   1'b0, 1'b0, 64'h0, 24'h0},
      {UNIT_DOT,   1'b1, 1'b1, 64'h7E31_2020_2020_2020, 24'h202020},
      {16'hFFFF,   1'b1, 1'b1, 64'h5F7E_3120_2020_2020, 24'h202020},
      {16'h0000,   1'b1, 1'b1, 64'h007E_3120_2020_2020, 24'h202020},
      {UNIT_SPACE, 1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0061,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0080,   1'b1, 1'b1, 64'h415F_7E31_2020_2020, 24'h202020},
      {16'h0062,   1'b0, 1'b0, 64'h0, 24'h0},
      {UNIT_DOT,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0063,   1'b0, 1'b0, 64'h0, 24'h0},
      {UNIT_DOT,   1'b1, 1'b1, 64'h427E_3120_2020_2020, 24'h202020},
      {UNIT_DOT,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0078,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0079,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h007A,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0031,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0032,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0033,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0034,   1'b0, 1'b0, 64'h0, 24'h0},
      {UNIT_DOT,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0061,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0062,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0063,   1'b0, 1'b0, 64'h0, 24'h0},
      {16'h0064,   1'b1, 1'b1, 64'h5859_5A31_3233_7E31, 24'h414243}
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   fsng_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   fsng_rsp_type rsp_data;

   logic         req_go = 1'b0;
   logic         rsp_go = 1'b0;
   fsng_req_type req_seen;
   fsng_rsp_type rsp_seen;

   name_row_type name_units [$];
   fsng_rsp_type short_name_q [$];
   int           unit_count = 0;
   int           name_count = 0;
   int           fail_count = 0;
   int           quiet_cycles = 0;

   fsng_phase_type name_phase = PHASE_LEAD;
   logic [47:0]    base_acc = '0;
   int             base_len = 0;
   logic [23:0]    ext_acc = '0;
   int             ext_len = 0;
   bit             dot_seen = 1'b0;

   fat_short_name_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // sample handshakes away from the active edge
   always @(negedge clock) begin
      req_go   = req_valid && req_ready;
      rsp_go   = rsp_valid && rsp_ready;
      req_seen = req_data;
      rsp_seen = rsp_data;
   end

   function automatic logic [7:0] short_char(logic [15:0] unit);
      logic [7:0] c;
      c = {1'b0, unit[6:0]};
      if (unit > UNIT_ASCII_MAX) begin
         c = BYTE_UNDERSCORE;
      end else if (c >= BYTE_LOWER_A && c <= BYTE_LOWER_Z) begin
         c = c - CASE_OFFSET;
      end
      return c;
   endfunction

   task automatic take_unit(input fsng_req_type beat, output bit done,
                            output fsng_rsp_type sn);
      logic [7:0] c;
      logic [7:0] b [0:10];
      logic [7:0] lfn_sum;
      int         n;
      if (name_phase == PHASE_LEAD && beat.name_unit != UNIT_DOT) begin
         name_phase = PHASE_BASE;
      end
      if (name_phase != PHASE_LEAD) begin
         if (beat.name_unit == UNIT_DOT) begin
            name_phase = PHASE_EXT;
            dot_seen   = 1'b1;
            ext_acc    = '0;
            ext_len    = 0;
         end else if (beat.name_unit != UNIT_SPACE) begin
            c = short_char(beat.name_unit);
            if (name_phase == PHASE_BASE) begin
               if (base_len < BASE_MAX) begin
                  base_acc = {base_acc[39:0], c};
                  base_len++;
               end
            end else if (dot_seen && ext_len < EXT_MAX) begin
               ext_acc = {ext_acc[15:0], c};
               ext_len++;
            end
         end
      end
      done = beat.last_unit;
      sn   = '0;
      if (done) begin
         n = 0;
         for (int i = 0; i < base_len; i++) begin
            b[n] = base_acc[8*(base_len-1-i) +: 8];
            n++;
         end
         b[n]     = BYTE_TILDE;
         b[n + 1] = BYTE_ONE;
         n += 2;
         while (n < BASE_BYTES) begin
            b[n] = BYTE_SPACE;
            n++;
         end
         for (int i = 0; i < ext_len; i++) begin
            b[n] = ext_acc[8*(ext_len-1-i) +: 8];
            n++;
         end
         while (n < BASE_BYTES + EXT_MAX) begin
            b[n] = BYTE_SPACE;
            n++;
         end
         lfn_sum = '0;
         for (int i = 0; i < BASE_BYTES + EXT_MAX; i++) begin
            lfn_sum = ((lfn_sum >> 1) | (lfn_sum << 7)) + b[i];
         end
         sn.base_bytes = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
         sn.ext_bytes  = {b[8], b[9], b[10]};
         sn.name_sum   = lfn_sum;
         name_phase = PHASE_LEAD;
         base_acc   = '0;
         base_len   = 0;
         ext_acc    = '0;
         ext_len    = 0;
         dot_seen   = 1'b0;
      end
   endtask

   function automatic logic [15:0] rand_unit();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 16'h0061 + 16'($urandom_range(25));
      if (r < 52) return 16'h0041 + 16'($urandom_range(25));
      if (r < 60) return 16'h0030 + 16'($urandom_range(9));
      if (r < 72) return UNIT_DOT;
      if (r < 78) return UNIT_SPACE;
      if (r < 88) return 16'($urandom_range(16'h007F));
      return 16'($urandom);
   endfunction

   function automatic bit send_idle(int idx);
      if (idx >= 300 && idx < 700) return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   always @(posedge clock) begin : scoreboard
      bit           done;
      fsng_rsp_type sn;
      fsng_rsp_type want;
      if (!reset) begin
         if (rsp_go) begin
            name_count++;
            if (short_name_q.size() == 0) begin
               $error("rsp beat with no short name pending: %h", rsp_seen);
               fail_count++;
            end else begin
               want = short_name_q.pop_front();
               if (rsp_seen.base_bytes !== want.base_bytes) begin
                  $error("base_bytes expected %h got %h", want.base_bytes, rsp_seen.base_bytes);
                  fail_count++;
               end
               if (rsp_seen.ext_bytes !== want.ext_bytes) begin
                  $error("ext_bytes expected %h got %h", want.ext_bytes, rsp_seen.ext_bytes);
                  fail_count++;
               end
               if (rsp_seen.name_sum !== want.name_sum) begin
                  $error("name_sum expected %h got %h", want.name_sum, rsp_seen.name_sum);
                  fail_count++;
               end
            end
         end
         if (req_go) begin
            take_unit(req_seen, done, sn);
            if (done) begin
               if (name_units[unit_count].typed) begin
                  sn.base_bytes = name_units[unit_count].base;
                  sn.ext_bytes  = name_units[unit_count].ext;
               end
               short_name_q.push_back(sn);
            end
            unit_count++;
         end
         if (req_go || rsp_go) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("fat_short_name_generator_tb NOT OK");
            $finish;
         end
      end
   end

   // receiver: random stalls, a clean stretch, and one long hold-off
   initial begin : receiver
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && name_count >= 60) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (name_count >= 150 && name_count < 300) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
         end
         @(posedge clock);
      end
   end

   initial begin : sender
      name_row_type row;
      int           len;
      int           dots;
      bit           mid_pause_done;
      mid_pause_done = 1'b0;
      for (int i = 0; i < NAME_TABLE_LEN; i++) name_units.push_back(NAME_TABLE[i]);
      while (name_units.size() < NAME_TABLE_LEN + RANDOM_UNITS) begin
         len  = ($urandom_range(9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 12);
         dots = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
         for (int k = 0; k < len; k++) begin
            row = '0;
            row.beat.name_unit = (k < dots) ? UNIT_DOT : rand_unit();
            row.beat.last_unit = (k == len - 1);
            name_units.push_back(row);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < name_units.size(); i++) begin
         if (i > 0 && name_units[i-1].beat.last_unit &&
             (i == NAME_TABLE_LEN || (i >= 800 && !mid_pause_done))) begin
            if (i >= 800) mid_pause_done = 1'b1;
            // drain before the next name
            req_valid <= 1'b0;
            @(posedge clock);
            while (short_name_q.size() != 0) @(posedge clock);
         end
         while (send_idle(i)) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= name_units[i].beat;
         do @(posedge clock); while (!req_go);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (short_name_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("fat_short_name_generator_tb OK");
      end else begin
         $display("fat_short_name_generator_tb NOT OK");
      end
      $finish;
   end

endmodule
